// ===== rtl/core/stable_voice_lane_allocator_assert.svh =====
// Assertion macros shared by the lane allocator RTL.
// Depends on nothing; included by the top allocator module, which carries the assertions.
`ifndef STABLE_VOICE_LANE_ALLOCATOR_ASSERT_SVH
`define STABLE_VOICE_LANE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SVLA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SVLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/svla_pkg.sv =====
// Package of the stable voice lane allocator: beat types and fixed constants.
// Depends on nothing; used by the interfaces and modules of the block.
`default_nettype none

package svla_pkg;

  localparam int unsigned SET_SIZE  = 6;
  localparam int unsigned NOTE_W    = 7;
  localparam int unsigned LANE_W    = 8;
  localparam int unsigned COUNT_W   = 3;
  localparam int unsigned OUT_LANES = 6;

  localparam logic [LANE_W-1:0] FREE_MARK = 8'hFF;

  typedef logic [NOTE_W-1:0] note_t;
  typedef logic [LANE_W-1:0] lane_t;

  typedef struct packed {
    note_t              note_0;
    note_t              note_1;
    note_t              note_2;
    note_t              note_3;
    note_t              note_4;
    note_t              note_5;
    logic [COUNT_W-1:0] note_count;
    logic [31:0]        stamp_ms;
    logic               link_up;
    logic               output_on;
  } in_beat_t;

  typedef struct packed {
    lane_t       lane_0;
    lane_t       lane_1;
    lane_t       lane_2;
    lane_t       lane_3;
    lane_t       lane_4;
    lane_t       lane_5;
    logic [31:0] snap_stamp_ms;
    logic        snap_link_up;
    logic        snap_output_on;
  } out_beat_t;

endpackage

`default_nettype wire

// ===== rtl/core/svla_if.sv =====
// Valid/ready channel interfaces for the note-set input and the lane result.
// Depends on svla_pkg for the beat types.
`default_nettype none

interface svla_in_if;
  logic              valid;
  logic              ready;
  svla_pkg::in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface svla_out_if;
  logic               valid;
  logic               ready;
  svla_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/svla_match.sv =====
// Comparator matrix: which lanes keep their note and which set notes are new.
// Depends on svla_pkg.
`default_nettype none

module svla_match #(
  parameter int unsigned LANE_COUNT = 6
) (
  input  wire logic [LANE_COUNT-1:0][svla_pkg::LANE_W-1:0] lanes,
  input  wire logic [svla_pkg::SET_SIZE-1:0][svla_pkg::NOTE_W-1:0] notes,
  input  wire logic [svla_pkg::COUNT_W-1:0] note_count,
  output logic [LANE_COUNT-1:0] keep,
  output logic [svla_pkg::SET_SIZE-1:0] unmatched
);

  logic [svla_pkg::COUNT_W-1:0] count_cap;
  logic [svla_pkg::SET_SIZE-1:0] note_valid;
  logic [LANE_COUNT-1:0][svla_pkg::SET_SIZE-1:0] eq;
  logic [svla_pkg::SET_SIZE-1:0] seen;
  logic [svla_pkg::SET_SIZE-1:0] dup;

  // A count of seven means the full set.
  assign count_cap = (note_count > svla_pkg::COUNT_W'(svla_pkg::SET_SIZE)) ?
                     svla_pkg::COUNT_W'(svla_pkg::SET_SIZE) : note_count;

  always_comb begin
    for (int i = 0; i < svla_pkg::SET_SIZE; i++) begin
      note_valid[i] = (svla_pkg::COUNT_W'(i) < count_cap);
    end
    for (int k = 0; k < LANE_COUNT; k++) begin
      for (int i = 0; i < svla_pkg::SET_SIZE; i++) begin
        eq[k][i] = note_valid[i] && (lanes[k] == {1'b0, notes[i]});
      end
      keep[k] = |eq[k];
    end
    for (int i = 0; i < svla_pkg::SET_SIZE; i++) begin
      seen[i] = 1'b0;
      dup[i]  = 1'b0;
      for (int k = 0; k < LANE_COUNT; k++) begin
        seen[i] = seen[i] | eq[k][i];
      end
      for (int j = 0; j < i; j++) begin
        dup[i] = dup[i] | (notes[j] == notes[i]);
      end
      // Only the first copy of a note can be claimed by a lane.
      unmatched[i] = note_valid[i] && !(seen[i] && !dup[i]);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/svla_fill.sv =====
// Priority fill: the n-th new note goes to the n-th free lane, lowest first.
// Depends on svla_pkg.
`default_nettype none

module svla_fill #(
  parameter int unsigned LANE_COUNT = 6
) (
  input  wire logic [LANE_COUNT-1:0][svla_pkg::LANE_W-1:0] lanes,
  input  wire logic [svla_pkg::SET_SIZE-1:0][svla_pkg::NOTE_W-1:0] notes,
  input  wire logic [LANE_COUNT-1:0] keep,
  input  wire logic [svla_pkg::SET_SIZE-1:0] unmatched,
  output logic [LANE_COUNT-1:0][svla_pkg::LANE_W-1:0] lanes_upd
);

  localparam int unsigned RANK_W = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
  localparam int unsigned CMP_W  = (RANK_W > svla_pkg::COUNT_W) ? RANK_W :
                                   svla_pkg::COUNT_W;

  logic [LANE_COUNT-1:0] free;
  logic [LANE_COUNT-1:0][RANK_W-1:0] free_rank;
  logic [svla_pkg::SET_SIZE-1:0][svla_pkg::COUNT_W-1:0] note_rank;

  assign free = ~keep;

  for (genvar k = 0; k < LANE_COUNT; k++) begin : g_lane
    localparam logic [LANE_COUNT-1:0] BELOW = LANE_COUNT'((64'd1 << k) - 64'd1);
    logic                 hit;
    svla_pkg::note_t      pick;

    assign free_rank[k] = RANK_W'($countones(free & BELOW));

    always_comb begin
      hit  = 1'b0;
      pick = '0;
      for (int i = 0; i < svla_pkg::SET_SIZE; i++) begin
        if (unmatched[i] && (CMP_W'(note_rank[i]) == CMP_W'(free_rank[k]))) begin
          hit  = 1'b1;
          pick = notes[i];
        end
      end
      if (keep[k]) begin
        lanes_upd[k] = lanes[k];
      end else if (hit) begin
        lanes_upd[k] = {1'b0, pick};
      end else begin
        lanes_upd[k] = svla_pkg::FREE_MARK;
      end
    end
  end

  for (genvar i = 0; i < svla_pkg::SET_SIZE; i++) begin : g_note
    localparam logic [svla_pkg::SET_SIZE-1:0] BEFORE =
      svla_pkg::SET_SIZE'((64'd1 << i) - 64'd1);
    assign note_rank[i] = svla_pkg::COUNT_W'($countones(unmatched & BEFORE));
  end

endmodule

`default_nettype wire

// ===== rtl/core/stable_voice_lane_allocator.sv =====
// Stable voice lane allocator: an accepted input beat passes the input register,
// then its result beat waits on the output register; one beat per cycle is
// sustained while the result side is ready. The rate is set by the comparator
// matrix and fill between the two registers, which also updates the lane state.
// Synchronous active-low reset frees every lane (255) and empties both registers.
// Depends on svla_pkg, svla_if, svla_match, svla_fill and the assertion macros.
`default_nettype none
`include "stable_voice_lane_allocator_assert.svh"

module stable_voice_lane_allocator #(
  parameter int unsigned LANE_COUNT = 6
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  svla_in_if.sink    in_ch,
  svla_out_if.source out_ch
);

  // Lane state: one note per lane, or the free mark.
  logic [LANE_COUNT-1:0][svla_pkg::LANE_W-1:0] lane_notes_r;
  logic [LANE_COUNT-1:0][svla_pkg::LANE_W-1:0] lane_notes_nxt;

  // Input register holds one note set; the result register holds one result.
  logic                in_valid_r;
  svla_pkg::in_beat_t  in_data_r;
  logic                out_valid_r;
  svla_pkg::out_beat_t out_data_r;
  svla_pkg::out_beat_t out_data_nxt;

  logic advance;
  logic [svla_pkg::SET_SIZE-1:0][svla_pkg::NOTE_W-1:0] notes;
  logic [LANE_COUNT-1:0] keep;
  logic [svla_pkg::SET_SIZE-1:0] unmatched;
  logic [svla_pkg::OUT_LANES-1:0][svla_pkg::LANE_W-1:0] shown;

  // The set in the input register is processed when the result register is
  // empty or being drained this cycle. The lane state updates at that same
  // edge, so consecutive sets see each other's effect in order.
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  assign notes[0] = in_data_r.note_0;
  assign notes[1] = in_data_r.note_1;
  assign notes[2] = in_data_r.note_2;
  assign notes[3] = in_data_r.note_3;
  assign notes[4] = in_data_r.note_4;
  assign notes[5] = in_data_r.note_5;

  svla_match #(.LANE_COUNT(LANE_COUNT)) u_match (
    .lanes      (lane_notes_r),
    .notes      (notes),
    .note_count (in_data_r.note_count),
    .keep       (keep),
    .unmatched  (unmatched)
  );

  svla_fill #(.LANE_COUNT(LANE_COUNT)) u_fill (
    .lanes     (lane_notes_r),
    .notes     (notes),
    .keep      (keep),
    .unmatched (unmatched),
    .lanes_upd (lane_notes_nxt)
  );

  // Lanes past the configured count are shown as free; lanes past the sixth
  // are kept in state but never shown.
  for (genvar k = 0; k < svla_pkg::OUT_LANES; k++) begin : g_show
    if (k < LANE_COUNT) begin : g_real
      assign shown[k] = lane_notes_nxt[k];
    end else begin : g_none
      assign shown[k] = svla_pkg::FREE_MARK;
    end
  end

  always_comb begin
    out_data_nxt.lane_0         = shown[0];
    out_data_nxt.lane_1         = shown[1];
    out_data_nxt.lane_2         = shown[2];
    out_data_nxt.lane_3         = shown[3];
    out_data_nxt.lane_4         = shown[4];
    out_data_nxt.lane_5         = shown[5];
    out_data_nxt.snap_stamp_ms  = in_data_r.stamp_ms;
    out_data_nxt.snap_link_up   = in_data_r.link_up;
    out_data_nxt.snap_output_on = in_data_r.output_on;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      lane_notes_r <= {LANE_COUNT{svla_pkg::FREE_MARK}};
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r  <= 1'b1;
        lane_notes_r <= lane_notes_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers load without reset.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_data_r <= in_ch.data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // A stalled set stays in the input register.
  `SVLA_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid_r && !advance, in_valid_r,
    "input set lost while stalled")
  // Processing a set always leaves a result waiting.
  `SVLA_ASSERT_NEXT(a_out_fill, clk, rst_n, advance, out_valid_r,
    "processed set produced no result")
  // Lane 0, when it found its note in the set, keeps it unchanged.
  `SVLA_ASSERT_NEXT(a_keep_lane, clk, rst_n, advance && keep[0],
    lane_notes_r[0] == $past(lane_notes_r[0]), "kept lane changed its note")
  // Lane 0 holds either a valid note number or the free mark.
  `SVLA_ASSERT_NOW(a_lane_code, clk, rst_n, lane_notes_r[0][svla_pkg::LANE_W-1],
    lane_notes_r[0] == svla_pkg::FREE_MARK, "lane holds a bad code")

endmodule

`default_nettype wire

// ===== tb/tb_stable_voice_lane_allocator.sv =====
// Self-checking testbench for the stable voice lane allocator.
// Depends on svla_pkg, the svla_in_if/svla_out_if channels and the allocator RTL.
`timescale 1ns / 1ps

module tb_stable_voice_lane_allocator;

  // The DUT runs with the usual six lanes, which are all visible in the result.
  localparam int unsigned LANES        = 6;
  // Bound on any wait for outstanding results, and the tail after the last one.
  localparam int unsigned DRAIN_LIMIT  = 4000;
  localparam int unsigned TAIL_CYCLES  = 8;
  // Hard stop for the whole run (in ns). The slowest correct run is well under a tenth of it.
  localparam int unsigned TIMEOUT_NS   = 5_000_000;

  logic clk;
  logic rst_n;

  svla_in_if  in_ch ();
  svla_out_if out_ch ();

  stable_voice_lane_allocator #(
    .LANE_COUNT(LANES)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Predicted lane contents, updated once per accepted note set.
  svla_pkg::lane_t     lanes_held[LANES];
  // Lane snapshots still owed by the DUT, oldest first.
  svla_pkg::out_beat_t snapshots_due[$];
  // Last note set generated, so random sets can evolve from it.
  svla_pkg::in_beat_t  last_set;

  // Idle/stall switches for the two sides of the DUT.
  bit          tx_idle_on;
  bit          rx_idle_on;

  int unsigned mismatches;
  int unsigned sets_sent;
  int unsigned beats_checked;
  int unsigned sets_with_repeats;
  int unsigned sets_with_drops;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard limit: a hung handshake or a lost beat ends the run here.
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout: the run did not reach its end.");
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_fault(input string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  // Lane update for one note set. Every lane first looks for its note among the
  // active notes; the first equal position counts as taken, even when another
  // lane already took it, so lanes holding the same note all survive. Lanes
  // that find nothing are freed. The untaken notes then go, in set order, to
  // the lowest free lane, and are lost once no lane is free.
  function automatic svla_pkg::out_beat_t allocate_notes(input svla_pkg::in_beat_t b);
    svla_pkg::note_t     set_notes[svla_pkg::SET_SIZE];
    bit                  taken[svla_pkg::SET_SIZE];
    svla_pkg::lane_t     view[svla_pkg::OUT_LANES];
    int unsigned         active;
    bit                  keep;
    bit                  placed;
    bit                  repeats;
    bit                  dropped;
    svla_pkg::out_beat_t r;
    set_notes = '{b.note_0, b.note_1, b.note_2, b.note_3, b.note_4, b.note_5};
    // A count of seven is clipped to the full set.
    active  = (b.note_count > svla_pkg::SET_SIZE) ? svla_pkg::SET_SIZE : b.note_count;
    repeats = 1'b0;
    dropped = 1'b0;
    for (int i = 0; i < svla_pkg::SET_SIZE; i++) taken[i] = 1'b0;

    for (int k = 0; k < LANES; k++) begin
      keep = 1'b0;
      // A free lane (255) can never equal a 7-bit note.
      for (int i = 0; i < active; i++) begin
        if (!keep && lanes_held[k] == {1'b0, set_notes[i]}) begin
          keep     = 1'b1;
          taken[i] = 1'b1;
        end
      end
      if (!keep) lanes_held[k] = svla_pkg::FREE_MARK;
    end

    for (int i = 0; i < active; i++) begin
      if (!taken[i]) begin
        placed = 1'b0;
        for (int k = 0; k < LANES; k++) begin
          if (!placed && lanes_held[k] == svla_pkg::FREE_MARK) begin
            lanes_held[k] = {1'b0, set_notes[i]};
            placed        = 1'b1;
          end
        end
        if (!placed) dropped = 1'b1;
      end
      for (int j = i + 1; j < active; j++) begin
        if (set_notes[i] == set_notes[j]) repeats = 1'b1;
      end
    end
    if (repeats) sets_with_repeats++;
    if (dropped) sets_with_drops++;

    // Lanes beyond the configured count always show as free.
    for (int k = 0; k < svla_pkg::OUT_LANES; k++) begin
      view[k] = (k < LANES) ? lanes_held[k] : svla_pkg::FREE_MARK;
    end
    r.lane_0         = view[0];
    r.lane_1         = view[1];
    r.lane_2         = view[2];
    r.lane_3         = view[3];
    r.lane_4         = view[4];
    r.lane_5         = view[5];
    r.snap_stamp_ms  = b.stamp_ms;
    r.snap_link_up   = b.link_up;
    r.snap_output_on = b.output_on;
    return r;
  endfunction

  function automatic svla_pkg::in_beat_t note_set(
      input svla_pkg::note_t n0, input svla_pkg::note_t n1, input svla_pkg::note_t n2,
      input svla_pkg::note_t n3, input svla_pkg::note_t n4, input svla_pkg::note_t n5,
      input logic [svla_pkg::COUNT_W-1:0] cnt,
      input logic [31:0] stamp,
      input logic lk, input logic on);
    svla_pkg::in_beat_t b;
    b.note_0     = n0;
    b.note_1     = n1;
    b.note_2     = n2;
    b.note_3     = n3;
    b.note_4     = n4;
    b.note_5     = n5;
    b.note_count = cnt;
    b.stamp_ms   = stamp;
    b.link_up    = lk;
    b.output_on  = on;
    return b;
  endfunction

  // Random note sets. Most evolve from the previous set, the way a player holds
  // some keys and changes others, so lanes really get kept and reused. Notes are
  // drawn mostly from a narrow range to make repeats and matches frequent. Some
  // sets duplicate notes on purpose, and a few are pure noise.
  function automatic svla_pkg::in_beat_t next_random_set();
    svla_pkg::in_beat_t b;
    svla_pkg::note_t    n[svla_pkg::SET_SIZE];
    svla_pkg::note_t    tmp;
    int unsigned        mode;
    int unsigned        a;
    int unsigned        c;
    n    = '{last_set.note_0, last_set.note_1, last_set.note_2,
             last_set.note_3, last_set.note_4, last_set.note_5};
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      for (int i = 0; i < svla_pkg::SET_SIZE; i++) begin
        n[i] = svla_pkg::note_t'($urandom_range(0, 127));
      end
    end else if (mode < 8) begin
      repeat ($urandom_range(0, 2)) begin
        n[$urandom_range(0, svla_pkg::SET_SIZE - 1)] = ($urandom_range(0, 3) == 0) ?
            svla_pkg::note_t'($urandom_range(0, 127)) :
            svla_pkg::note_t'($urandom_range(56, 67));
      end
      if ($urandom_range(0, 3) == 0) begin
        a    = $urandom_range(0, svla_pkg::SET_SIZE - 1);
        c    = $urandom_range(0, svla_pkg::SET_SIZE - 1);
        tmp  = n[a];
        n[a] = n[c];
        n[c] = tmp;
      end
    end else begin
      repeat ($urandom_range(1, 3)) begin
        n[$urandom_range(0, svla_pkg::SET_SIZE - 1)] = n[$urandom_range(0, 2)];
      end
    end
    b = note_set(n[0], n[1], n[2], n[3], n[4], n[5], '0, $urandom(),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    if (mode < 2 || $urandom_range(0, 3) == 0) begin
      b.note_count = 3'($urandom_range(0, 7));
    end else begin
      b.note_count = 3'($urandom_range(3, 6));
    end
    last_set = b;
    return b;
  endfunction

  // Sends one note set. Entered and left at a falling edge; the valid line is
  // left high so the next call can follow back to back. The expected snapshot
  // is computed at the edge where the beat is accepted.
  task automatic send_set(input svla_pkg::in_beat_t b);
    int unsigned gap;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    snapshots_due.push_back(allocate_notes(b));
    sets_sent++;
    @(negedge clk);
  endtask

  // Drops valid and waits until every owed snapshot has come out. At least one
  // edge passes, so valid is never lowered and raised in the same step.
  task automatic wait_for_drain();
    int unsigned spins;
    in_ch.valid <= 1'b0;
    spins = 0;
    do begin
      @(posedge clk);
      spins++;
    end while (snapshots_due.size() != 0 && spins < DRAIN_LIMIT);
    @(negedge clk);
  endtask

  // Right after reset every lane is free: empty sets must report six free lanes,
  // and notes beyond the count must be ignored.
  task automatic test_idle_lanes_after_reset();
    send_set(note_set(0, 0, 0, 0, 0, 0, 0, 32'h0000_0000, 1'b0, 1'b0));
    send_set(note_set(127, 127, 127, 127, 127, 127, 0, 32'hFFFF_FFFF, 1'b1, 1'b1));
  endtask

  // Extreme note values, a full set, a count of seven, a reordered set that must
  // leave the lanes in place, and a complete change of notes.
  task automatic test_field_extremes();
    send_set(note_set(0, 127, 1, 126, 64, 63, 6, 32'hFFFF_FFFF, 1'b1, 1'b1));
    send_set(note_set(0, 127, 1, 126, 64, 63, 7, 32'h8000_0000, 1'b0, 1'b1));
    send_set(note_set(63, 64, 126, 1, 127, 0, 6, 32'h0000_0001, 1'b1, 1'b0));
    send_set(note_set(127, 0, 42, 42, 42, 42, 2, 32'h7FFF_FFFF, 1'b0, 1'b0));
    send_set(note_set(5, 6, 7, 8, 9, 10, 6, 32'h0000_0000, 1'b1, 1'b1));
  endtask

  // Counts between one and five: held notes released, new ones slotted into the
  // lowest free lanes, and junk past the count ignored.
  task automatic test_partial_count();
    send_set(note_set(5, 6, 7, 99, 98, 97, 3, 32'h1234_5678, 1'b1, 1'b0));
    send_set(note_set(7, 99, 6, 5, 1, 2, 5, 32'hEDCB_A987, 1'b0, 1'b1));
    send_set(note_set(99, 3, 4, 5, 6, 7, 1, 32'h5555_5555, 1'b1, 1'b0));
    send_set(note_set(1, 2, 3, 4, 5, 6, 4, 32'hAAAA_AAAA, 1'b0, 1'b1));
  endtask

  // Repeated notes in a set: lanes holding the same note all keep it, later
  // equal positions take further lanes, and surplus notes are lost when every
  // lane is busy.
  task automatic test_repeated_notes();
    send_set(note_set(0, 0, 0, 0, 0, 0, 0, 32'h0F0F_0F0F, 1'b0, 1'b0));
    send_set(note_set(60, 60, 60, 1, 2, 3, 2, 32'hF0F0_F0F0, 1'b1, 1'b1));
    send_set(note_set(60, 11, 12, 13, 14, 15, 6, 32'h3333_3333, 1'b1, 1'b0));
    send_set(note_set(60, 60, 60, 60, 60, 60, 6, 32'hCCCC_CCCC, 1'b0, 1'b1));
    send_set(note_set(60, 61, 62, 63, 64, 65, 6, 32'h0000_FFFF, 1'b1, 1'b1));
    send_set(note_set(61, 62, 63, 64, 65, 66, 7, 32'hFFFF_0000, 1'b0, 1'b0));
  endtask

  task automatic test_random_sets(input int unsigned n);
    repeat (n) send_set(next_random_set());
  endtask

  // The sender holds off until the DUT has nothing left to deliver, then
  // resumes; this puts an input beat onto a fully idle pipeline.
  task automatic test_pause_until_drained();
    wait_for_drain();
    test_random_sets(10);
    wait_for_drain();
  endtask

  // Closing stretch with no idling on either side: one beat per cycle.
  task automatic test_back_to_back(input int unsigned n);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_sets(n);
  endtask

  // Result side: ready drops at random while stalling is on.
  initial begin
    int unsigned stall_left;
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 5);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Every accepted result beat is matched against the oldest owed snapshot,
  // one field at a time.
  always @(posedge clk) begin : check_lane_beats
    svla_pkg::out_beat_t got;
    svla_pkg::out_beat_t want;
    svla_pkg::lane_t     got_lanes[svla_pkg::OUT_LANES];
    svla_pkg::lane_t     want_lanes[svla_pkg::OUT_LANES];
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (snapshots_due.size() == 0) begin
        report_fault($sformatf("result beat with no note set pending, stamp %h",
                               got.snap_stamp_ms));
      end else begin
        want = snapshots_due.pop_front();
        beats_checked++;
        got_lanes  = '{got.lane_0, got.lane_1, got.lane_2,
                       got.lane_3, got.lane_4, got.lane_5};
        want_lanes = '{want.lane_0, want.lane_1, want.lane_2,
                       want.lane_3, want.lane_4, want.lane_5};
        for (int k = 0; k < svla_pkg::OUT_LANES; k++) begin
          if (got_lanes[k] !== want_lanes[k]) begin
            report_fault($sformatf("beat %0d lane_%0d: got %0d, want %0d",
                                   beats_checked, k, got_lanes[k], want_lanes[k]));
          end
        end
        if (got.snap_stamp_ms !== want.snap_stamp_ms) begin
          report_fault($sformatf("beat %0d snap_stamp_ms: got %h, want %h",
                                 beats_checked, got.snap_stamp_ms, want.snap_stamp_ms));
        end
        if (got.snap_link_up !== want.snap_link_up) begin
          report_fault($sformatf("beat %0d snap_link_up: got %b, want %b",
                                 beats_checked, got.snap_link_up, want.snap_link_up));
        end
        if (got.snap_output_on !== want.snap_output_on) begin
          report_fault($sformatf("beat %0d snap_output_on: got %b, want %b",
                                 beats_checked, got.snap_output_on, want.snap_output_on));
        end
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    last_set    = '0;
    for (int k = 0; k < LANES; k++) lanes_held[k] = svla_pkg::FREE_MARK;

    // Hold reset low, then release it at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_idle_lanes_after_reset();
    test_field_extremes();
    test_partial_count();
    test_repeated_notes();
    test_random_sets(300);
    test_pause_until_drained();
    test_random_sets(250);
    test_back_to_back(80);

    // Let the pipeline empty, then wait out the tail to show any stray beat
    // before the leftovers are counted.
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (snapshots_due.size() != 0) begin
      report_fault($sformatf("%0d expected result beats never arrived", snapshots_due.size()));
    end

    $display("Run covered %0d note sets and checked %0d result beats.", sets_sent, beats_checked);
    $display("Sets with repeated notes: %0d; sets that lost notes to a full lane bank: %0d.",
             sets_with_repeats, sets_with_drops);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/svla_pkg.sv
rtl/core/svla_if.sv
rtl/core/svla_match.sv
rtl/core/svla_fill.sv
rtl/core/stable_voice_lane_allocator.sv
tb/tb_stable_voice_lane_allocator.sv
